[hdl/p2h_pkg.sv]
// Shared widths, constants, result type and divisor helpers for the pixel to hex converter.
package p2h_pkg;

  localparam int PIX_W     = 24;
  localparam int SIZE_W    = 16;
  localparam int COORD_W   = 16;
  localparam int COORD_MAX = 32767;
  localparam int COORD_MIN = -32768;

  // Signed numerator width of both dividers and the quotient width they return.
  localparam int NUM_W  = 50;
  localparam int QUO_W  = 41;
  localparam int DENQ_W = 26;
  localparam int DENR_W = 18;

  // floor(sqrt(3) * 2^24) and the shifts that put y into the same scale.
  localparam int SQRT3_Q24 = 29058990;
  localparam int SQ_SHIFT  = 24;
  localparam int R_SHIFT   = 17;

  // Work format of the rounding stages: 16 fraction bits.
  localparam int WORK_FRAC = 16;
  localparam int WORK_HALF = 32768;
  localparam int WORK_ONE  = 65536;

  localparam logic [SIZE_W-1:0] CELL_SIZE_RST = SIZE_W'(256);

  localparam int FRONT_ST = 2;
  localparam int DIV_ST   = NUM_W + 2;
  localparam int BACK_ST  = 5;
  localparam int PIPE_ST  = FRONT_ST + DIV_ST + BACK_ST;

  typedef struct packed {
    logic                      sat;
    logic signed [COORD_W-1:0] row;
    logic signed [COORD_W-1:0] column;
  } res_t;

  // A cell size of zero is handled as one.
  function automatic logic [SIZE_W-1:0] size_eff_f(input logic [SIZE_W-1:0] size);
    return (size == '0) ? SIZE_W'(1) : size;
  endfunction

  // 768 * size, the divisor of the q term.
  function automatic logic [DENQ_W-1:0] den_q_f(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] s;
    s = size_eff_f(size);
    return DENQ_W'({s, 9'd0}) + DENQ_W'({s, 8'd0});
  endfunction

  // 3 * size, the divisor of the r term.
  function automatic logic [DENR_W-1:0] den_r_f(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] s;
    s = size_eff_f(size);
    return DENR_W'({s, 1'b0}) + DENR_W'(s);
  endfunction

endpackage

[hdl/p2h_front.sv]
// Front stages: sqrt(3) product and the two scaled numerators.
module p2h_front
  import p2h_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [PIX_W-1:0] x_i,
  input  logic signed [PIX_W-1:0] y_i,
  output logic signed [NUM_W-1:0] nq_o,
  output logic signed [NUM_W-1:0] nr_o
);

  localparam logic signed [NUM_W-1:0] SQRT3_C = NUM_W'(SQRT3_Q24);

  logic signed [NUM_W-1:0] prod_q;
  logic signed [PIX_W-1:0] y_q;
  logic signed [NUM_W-1:0] nq_q;
  logic signed [NUM_W-1:0] nr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= NUM_W'(x_i) * SQRT3_C;
      y_q    <= y_i;
      nq_q   <= prod_q - (NUM_W'(y_q) <<< SQ_SHIFT);
      nr_q   <= NUM_W'(y_q) <<< R_SHIFT;
    end
  end

  assign nq_o = nq_q;
  assign nr_o = nr_q;

endmodule

[hdl/p2h_div.sv]
// Pipelined restoring divider, one quotient bit per stage, floor rounding of a signed numerator.
module p2h_div
  import p2h_pkg::*;
#(
  parameter int DEN_W = 26
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [DEN_W-1:0]        den_i,
  input  logic signed [NUM_W-1:0] num_i,
  output logic signed [QUO_W-1:0] quo_o
);

  // Each step shifts one numerator bit into the partial remainder and
  // shifts the quotient bit into the bottom of the numerator word.
  logic [NUM_W-1:0] mag_q [NUM_W+1];
  logic [DEN_W-1:0] rem_q [NUM_W+1];
  logic             neg_q [NUM_W+1];
  logic [DEN_W:0]   trial [NUM_W];
  logic             fits  [NUM_W];
  logic [NUM_W-1:0] fix_d;
  logic signed [QUO_W-1:0] quo_q;

  always_comb begin
    for (int i = 0; i < NUM_W; i++) begin
      trial[i] = {rem_q[i], mag_q[i][NUM_W-1]};
      fits[i]  = trial[i] >= {1'b0, den_i};
    end
  end

  // For a negative numerator, floor(-Q - frac) is -Q when exact, else -Q - 1.
  always_comb begin
    if (neg_q[NUM_W]) begin
      fix_d = ~mag_q[NUM_W] + NUM_W'(rem_q[NUM_W] == '0);
    end else begin
      fix_d = mag_q[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= num_i[NUM_W-1];
      mag_q[0] <= num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
      rem_q[0] <= '0;
      for (int i = 0; i < NUM_W; i++) begin
        rem_q[i+1] <= fits[i] ? DEN_W'(trial[i] - {1'b0, den_i}) : trial[i][DEN_W-1:0];
        mag_q[i+1] <= {mag_q[i][NUM_W-2:0], fits[i]};
        neg_q[i+1] <= neg_q[i];
      end
      quo_q <= fix_d[QUO_W-1:0];
    end
  end

  assign quo_o = quo_q;

endmodule

[hdl/p2h_back.sv]
// Back stages: cube rounding, component rebuild, even-r offset and saturation.
module p2h_back
  import p2h_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [QUO_W-1:0] qf_i,
  input  logic signed [QUO_W-1:0] rf_i,
  output res_t                    res_o
);

  localparam int V_W = QUO_W + 1;
  localparam int R_W = V_W - WORK_FRAC + 1;
  localparam int E_W = WORK_FRAC + 1;
  localparam int S_W = R_W + 1;
  localparam int C_W = S_W + 1;

  localparam logic [V_W:0] T_HALF  = (V_W + 1)'(WORK_HALF);
  localparam logic [V_W:0] T_HALFM = (V_W + 1)'(WORK_HALF - 1);

  localparam logic signed [C_W-1:0] COL_MAX = C_W'(COORD_MAX);
  localparam logic signed [C_W-1:0] COL_MIN = C_W'(COORD_MIN);
  localparam logic signed [S_W-1:0] ROW_MAX = S_W'(COORD_MAX);
  localparam logic signed [S_W-1:0] ROW_MIN = S_W'(COORD_MIN);

  typedef struct packed {
    logic signed [R_W-1:0] r;
    logic [E_W-1:0]        d;
  } rnd_t;

  // Round half away from zero; negative values round with a bias one lower.
  function automatic rnd_t rnd_f(input logic signed [V_W-1:0] v);
    logic [V_W:0]   t;
    logic [E_W-1:0] frac;
    logic           up;
    rnd_t           res;
    frac  = {1'b0, v[WORK_FRAC-1:0]};
    t     = {v[V_W-1], v} + (v[V_W-1] ? T_HALFM : T_HALF);
    up    = frac >= (E_W'(WORK_HALF) + E_W'(v[V_W-1]));
    res.r = t[V_W:WORK_FRAC];
    res.d = up ? (E_W'(WORK_ONE) - frac) : frac;
    return res;
  endfunction

  logic signed [V_W-1:0] qv_q, rv_q, sv_q;
  rnd_t                  q1_q, r1_q, s1_q;
  logic signed [S_W-1:0] q2_d, r2_d, q2_q, r2_q;
  logic signed [S_W-1:0] qe, re, se;
  logic signed [S_W:0]   rsum;
  logic signed [S_W:0]   rhalf;
  logic signed [C_W-1:0] col3_q;
  logic signed [S_W-1:0] row3_q;
  res_t                  res_d, res_q;

  assign qe = S_W'($signed(q1_q.r));
  assign re = S_W'($signed(r1_q.r));
  assign se = S_W'($signed(s1_q.r));

  // The component with the largest rounding error is rebuilt from the others.
  always_comb begin
    q2_d = qe;
    r2_d = re;
    priority if (q1_q.d > s1_q.d && q1_q.d > r1_q.d) begin
      q2_d = -se - re;
    end else if (s1_q.d > r1_q.d) begin
      q2_d = qe;
    end else begin
      r2_d = -qe - se;
    end
  end

  // r + (r & 1) is always even, so the halving is exact.
  assign rsum  = {r2_q[S_W-1], r2_q} + {{S_W{1'b0}}, r2_q[0]};
  assign rhalf = rsum >>> 1;

  always_comb begin
    res_d.sat = 1'b0;
    priority if (col3_q > COL_MAX) begin
      res_d.column = COORD_W'(COORD_MAX);
      res_d.sat    = 1'b1;
    end else if (col3_q < COL_MIN) begin
      res_d.column = COORD_W'(COORD_MIN);
      res_d.sat    = 1'b1;
    end else begin
      res_d.column = col3_q[COORD_W-1:0];
    end
    priority if (row3_q > ROW_MAX) begin
      res_d.row = COORD_W'(COORD_MAX);
      res_d.sat = 1'b1;
    end else if (row3_q < ROW_MIN) begin
      res_d.row = COORD_W'(COORD_MIN);
      res_d.sat = 1'b1;
    end else begin
      res_d.row = row3_q[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qv_q   <= V_W'(qf_i);
      rv_q   <= V_W'(rf_i);
      sv_q   <= -V_W'(qf_i) - V_W'(rf_i);
      q1_q   <= rnd_f(qv_q);
      r1_q   <= rnd_f(rv_q);
      s1_q   <= rnd_f(sv_q);
      q2_q   <= q2_d;
      r2_q   <= r2_d;
      col3_q <= C_W'(q2_q) + rhalf;
      row3_q <= r2_q;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[hdl/pixel_to_hex_offset_core.sv]
// Top level: pixel position to even-r offset hex cell, pointy-top layout.
// Pipeline of 59 register stages; the two dividers produce one quotient bit per stage.
// A request passes the front, divider and back stages in turn before its result reaches the output register.
// Throughput is one request per cycle; the whole pipeline stalls only while a result waits.
// Reset clears the valid bits and sets the cell size to 256; no clearing pass is needed.
module pixel_to_hex_offset_core
  import p2h_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [47:0]       s_axis_tdata,   // pixel_x [23:0], pixel_y [47:24]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // column [15:0], row [31:16]
  output logic              m_axis_tuser    // saturated [0]
);

  logic [DENQ_W-1:0]       denq_q;
  logic [DENR_W-1:0]       denr_q;
  logic [PIPE_ST-1:0]      vld_q;
  logic                    en;
  logic signed [PIX_W-1:0] pix_x, pix_y;
  logic signed [NUM_W-1:0] nq, nr;
  logic signed [QUO_W-1:0] qf, rf;
  res_t                    res;

  // Divisors are derived once per write; the user must write only while the pipe is empty; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      denq_q <= den_q_f(CELL_SIZE_RST);
      denr_q <= den_r_f(CELL_SIZE_RST);
    end else if (cfg_we_i) begin
      denq_q <= den_q_f(cfg_wdata_i);
      denr_q <= den_r_f(cfg_wdata_i);
    end
  end

  assign en = !vld_q[PIPE_ST-1] || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_ST-2:0], s_axis_tvalid};
    end
  end

  assign pix_x = $signed(s_axis_tdata[PIX_W-1:0]);
  assign pix_y = $signed(s_axis_tdata[2*PIX_W-1:PIX_W]);

  p2h_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (pix_x),
    .y_i   (pix_y),
    .nq_o  (nq),
    .nr_o  (nr)
  );

  p2h_div #(
    .DEN_W (DENQ_W)
  ) u_div_q (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i (denq_q),
    .num_i (nq),
    .quo_o (qf)
  );

  p2h_div #(
    .DEN_W (DENR_W)
  ) u_div_r (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i (denr_q),
    .num_i (nr),
    .quo_o (rf)
  );

  p2h_back u_back (
    .clk_i (clk_i),
    .en_i  (en),
    .qf_i  (qf),
    .rf_i  (rf),
    .res_o (res)
  );

  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PIPE_ST-1];
  assign m_axis_tdata  = {res.row, res.column};
  assign m_axis_tuser  = res.sat;

endmodule

[hdl/p2h_checker.sv]
// Port-level checks for the pixel to hex converter and their binding to the top level.
module p2h_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [15:0] cfg_wdata_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  localparam logic [15:0] C_MAX = 16'h7fff;
  localparam logic [15:0] C_MIN = 16'h8000;

  // A result that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Requests are refused only while a finished result is held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // A clamped result carries a range limit in column or row.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[15:0] == C_MAX || m_axis_tdata[15:0] == C_MIN ||
      m_axis_tdata[31:16] == C_MAX || m_axis_tdata[31:16] == C_MIN)
    else $error("saturated flag without a clamped coordinate");

  // Once reset has been seen at an edge, nothing is offered at the next one.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind pixel_to_hex_offset_core p2h_checker u_p2h_checker (.*);
